>>> rtl/ccd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccd_pkg
// Shared types, constants and helpers for the container code check digit
// block.
// ---------------------------------------------------------------------------
package ccd_pkg;

  // Fixed field widths
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 4;
  localparam int RES_W    = 4;   // residue mod 11 and check digit
  localparam int VAL_W    = 6;   // letter value up to 38
  localparam int PROD_W   = 9;   // value times weight residue, at most 304
  localparam int QDEPTH   = 2;

  // Position limits
  localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
  localparam logic [POS_W-1:0] POS_LAST_LET = 4'd4;
  localparam logic [POS_W-1:0] POS_NO_CHECK = 4'd10;
  localparam logic [POS_W-1:0] POS_CHECK    = 4'd11;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  // Modulus and its reciprocal: floor(x / 11) == (x * 373) >> 12 for x < 512
  localparam logic [RES_W-1:0] MODULUS     = 4'd11;
  localparam logic [RES_W-1:0] RES_TEN     = 4'd10;
  localparam int               RECIP_11    = 373;
  localparam int               RECIP_SHIFT = 12;
  localparam int               RECIP_W     = PROD_W + RECIP_SHIFT - 2;

  // Letter values, 'A'..'Z', skipping multiples of eleven
  localparam logic [VAL_W-1:0] LETTER_VALUE [0:25] = '{
    6'd10, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
    6'd21, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd32, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
  };

  // 2^(pos-1) mod 11 for positions one to ten, zero elsewhere
  localparam logic [RES_W-1:0] WEIGHT_MOD [0:15] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9,
    4'd7, 4'd3, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // Result codes
  typedef enum logic [2:0] {
    ST_PASS      = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_CORRECTED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_BADLET    = 3'd4,
    ST_BADDIG    = 3'd5,
    ST_MISMATCH  = 3'd6,
    ST_MISSING   = 3'd7
  } status_t;

  // Classified character, front to back
  typedef struct packed {
    logic [RES_W-1:0]  term;     // weighted value mod 11, zero if not summed
    logic              let_err;
    logic              dig_err;
    logic              chk;      // check character position
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [POS_W-1:0] code_length;
    logic [RES_W-1:0] check_digit;
    logic             accepted;
    status_t          status;
  } result_t;

  // Residue mod 11 of a small product via reciprocal multiply
  function automatic logic [RES_W-1:0] mod11(input logic [PROD_W-1:0] x);
    logic [RECIP_W-1:0] p;
    logic [PROD_W-1:0]  q;
    logic [PROD_W-1:0]  r;
    p = RECIP_W'(x) * RECIP_W'(RECIP_11);
    q = PROD_W'(p >> RECIP_SHIFT);
    r = x - PROD_W'(q * PROD_W'(MODULUS));
    return r[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/container_code_check_digit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// container_code_check_digit
// Container code check digit over a character stream, with result status.
// ---------------------------------------------------------------------------
//  Channel  Dir  Ports                Payload
//  in       in   in_t*                tdata[7:0] char_code, tlast last
//  out      out  out_t*               tdata status, accepted, check_digit,
//                                     code_length
//  cfg      in   cfg_p*               reg 0 at 0x0: correct_enable
//
//  One character per cycle while the queue has room; the front classifies and
//  reduces the weighted value mod 11 in the accept cycle, the back adds it into
//  the running residue as it pops it, and a result is registered on the pop of
//  its last character. A two-entry queue parts front and back; an output stall
//  holds only last characters and fills the queue before in_tready drops.
//  Synchronous active-low reset clears counters, flags and the register.
// ---------------------------------------------------------------------------
module container_code_check_digit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] char_code
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [2:0] status, [3] accepted,
                                        // [7:4] check_digit, [11:8] code_length
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ccd_pkg::*;

  localparam logic [2:0] ADDR_CORRECT_ENABLE = 3'd0;

  logic    correct_enable_r, correct_enable_nxt;
  logic    push, push_ready, pop, q_valid;
  entry_t  push_entry, q_entry;
  result_t result;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_comb begin
    correct_enable_nxt = correct_enable_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_CORRECT_ENABLE))
      correct_enable_nxt = cfg_pwdata[0];
  end
  assign cfg_prdata = (cfg_paddr == ADDR_CORRECT_ENABLE) ? {31'd0, correct_enable_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      correct_enable_r <= 1'b0;
    end else begin
      correct_enable_r <= correct_enable_nxt;
    end
  end

  ccd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ccd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  ccd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .correct_enable (correct_enable_r),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_result     (result)
  );

  assign out_tdata = {4'd0, result};

`ifndef SYNTHESIS
  a_accepted_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3] == (out_tdata[2:0] <= 3'd2))
    else $error("accepted flag does not match status");
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] <= 4'd9)
    else $error("check digit out of range");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] != 4'd0)
    else $error("result with zero length");
`endif

endmodule
`default_nettype wire

>>> rtl/ccd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccd_front
// Accepts characters, tracks position, classifies each one and reduces its
// weighted value mod 11 before handing it to the queue.
// ---------------------------------------------------------------------------
module ccd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_char,
  input  wire logic                  in_last,
  output logic                       push,
  input  wire logic                  push_ready,
  output ccd_pkg::entry_t            push_entry
);
  import ccd_pkg::*;

  logic [POS_W-1:0]  position_r, position_nxt;
  logic [POS_W-1:0]  pos;
  logic              is_letter, is_digit;
  logic [CHAR_W-1:0] let_off, dig_off;
  logic [VAL_W-1:0]  val;
  logic [PROD_W-1:0] prod;

  // Position of this character, saturating
  assign pos = (position_r < POS_MAX) ? position_r + 4'd1 : POS_MAX;

  // Character classes
  assign is_letter = (in_char >= CH_UPPER_A) && (in_char <= CH_UPPER_Z);
  assign is_digit  = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign let_off   = in_char - CH_UPPER_A;
  assign dig_off   = in_char - CH_ZERO;

  // Value and weighted residue
  always_comb begin
    val = '0;
    if (pos <= POS_LAST_LET) begin
      if (is_letter) val = LETTER_VALUE[let_off[4:0]];
    end else if (pos <= POS_NO_CHECK) begin
      if (is_digit) val = VAL_W'(dig_off[3:0]);
    end
    prod = PROD_W'(val) * PROD_W'(WEIGHT_MOD[pos]);
  end

  always_comb begin
    push_entry.term    = mod11(prod);
    push_entry.let_err = (pos <= POS_LAST_LET) && !is_letter;
    push_entry.dig_err = (pos > POS_LAST_LET) && (pos <= POS_NO_CHECK) && !is_digit;
    push_entry.chk     = (pos == POS_CHECK);
    push_entry.ch      = in_char;
    push_entry.pos     = pos;
    push_entry.last    = in_last;
  end

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  // Position counter, cleared after the last character
  always_comb begin
    position_nxt = position_r;
    if (push) position_nxt = in_last ? '0 : pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ccd_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccd_queue
// Short FIFO of classified characters between front and back.
// ---------------------------------------------------------------------------
module ccd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       push_ready,
  input  wire ccd_pkg::entry_t       push_entry,
  input  wire logic                  pop,
  output logic                       pop_valid,
  output ccd_pkg::entry_t            pop_entry
);
  import ccd_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_W'(QDEPTH))
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

>>> rtl/ccd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccd_back
// Accumulates residue and error flags per code and issues the result item
// on the last character through an output register.
// ---------------------------------------------------------------------------
module ccd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  correct_enable,
  input  wire logic                  q_valid,
  input  wire ccd_pkg::entry_t       q_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ccd_pkg::result_t           out_result
);
  import ccd_pkg::*;

  logic [RES_W-1:0]  residue_r, residue_nxt;
  logic              let_err_r, let_err_nxt;
  logic              dig_err_r, dig_err_nxt;
  logic [CHAR_W-1:0] given_r, given_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           result_r, result_nxt;

  logic [RES_W:0]    sum;
  logic [RES_W-1:0]  res_new;
  logic              let_cur, dig_cur;
  logic [CHAR_W-1:0] given_cur;
  logic [RES_W-1:0]  die;
  status_t           status;

  // A last character needs a free output slot
  assign pop = q_valid && (!q_entry.last || !out_valid_r || out_ready);

  // Running residue including this character
  assign sum     = {1'b0, residue_r} + {1'b0, q_entry.term};
  assign res_new = (sum >= {1'b0, MODULUS}) ? RES_W'(sum - {1'b0, MODULUS}) : sum[RES_W-1:0];

  assign let_cur   = let_err_r | q_entry.let_err;
  assign dig_cur   = dig_err_r | q_entry.dig_err;
  assign given_cur = q_entry.chk ? q_entry.ch : given_r;
  assign die       = (res_new == RES_TEN) ? '0 : res_new;

  // Status decode, in priority order
  always_comb begin
    if (q_entry.pos < POS_NO_CHECK) status = ST_SHORT;
    else if (let_cur) status = ST_BADLET;
    else if (dig_cur) status = ST_BADDIG;
    else if (q_entry.pos == POS_NO_CHECK) status = correct_enable ? ST_APPENDED : ST_MISSING;
    else if ((q_entry.pos == POS_CHECK) && (given_cur != (CH_ZERO + CHAR_W'(die))))
      status = correct_enable ? ST_CORRECTED : ST_MISMATCH;
    else status = ST_PASS;
  end

  // Per-code state, cleared after the last character
  always_comb begin
    residue_nxt = residue_r;
    let_err_nxt = let_err_r;
    dig_err_nxt = dig_err_r;
    given_nxt   = given_r;
    if (pop) begin
      if (q_entry.last) begin
        residue_nxt = '0;
        let_err_nxt = 1'b0;
        dig_err_nxt = 1'b0;
        given_nxt   = '0;
      end else begin
        residue_nxt = res_new;
        let_err_nxt = let_cur;
        dig_err_nxt = dig_cur;
        given_nxt   = given_cur;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    result_nxt    = result_r;
    if (pop && q_entry.last) begin
      out_valid_nxt          = 1'b1;
      result_nxt.status      = status;
      result_nxt.accepted    = (status == ST_PASS) || (status == ST_APPENDED) ||
                               (status == ST_CORRECTED);
      result_nxt.check_digit = die;
      result_nxt.code_length = q_entry.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r   <= '0;
      let_err_r   <= 1'b0;
      dig_err_r   <= 1'b0;
      given_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      residue_r   <= residue_nxt;
      let_err_r   <= let_err_nxt;
      dig_err_r   <= dig_err_nxt;
      given_r     <= given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

`ifndef SYNTHESIS
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    residue_r < MODULUS)
    else $error("residue out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(result_r))
    else $error("pending result lost");
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.status == ST_SHORT) |-> result_r.code_length < POS_NO_CHECK)
    else $error("short status with full length");
`endif

endmodule
`default_nettype wire

>>> tb/ccd_code_checker.sv
// ---------------------------------------------------------------------------
// ccd_code_checker
// Watches the character, result and register channels of the container
// code check digit block. It keeps its own copy of the running check sum
// and of the correction setting. For every code it predicts the verdict
// and compares it field by field with the result item that comes out.
// ---------------------------------------------------------------------------
module ccd_code_checker #(
  parameter logic [2:0] CORRECT_EN_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] char_code
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,   // [2:0] status, [3] accepted,
                                        // [7:4] check_digit, [11:8] code_length
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic [31:0] cfg_prdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output logic [7:0]       status_seen
);
  import ccd_pkg::*;

  localparam logic [7:0] CHAR_A    = "A";
  localparam logic [7:0] CHAR_Z    = "Z";
  localparam logic [7:0] CHAR_0    = "0";
  localparam logic [7:0] CHAR_9    = "9";

  result_t     verdict_q[$];
  logic        corr_en;
  logic [13:0] code_sum;
  logic [3:0]  char_pos;
  logic        letter_bad;
  logic        digit_bad;
  logic [7:0]  check_char;

  // Letter value: counts up from 10 for 'A', stepping over multiples of 11
  function automatic logic [5:0] letter_value(input logic [7:0] ch);
    int v;
    v = 10;
    for (int k = 0; k < int'(ch - CHAR_A); k++) begin
      v++;
      if (v % 11 == 0) v++;
    end
    return 6'(v);
  endfunction

  function automatic void clear_code();
    code_sum   = '0;
    char_pos   = '0;
    letter_bad = 1'b0;
    digit_bad  = 1'b0;
    check_char = '0;
  endfunction

  // Fold one character into the running code; on last, queue the verdict
  function automatic void absorb_char(input logic [7:0] ch, input logic lst);
    logic [3:0] pos;
    logic [3:0] digit;
    status_t    st;
    result_t    r;
    pos = (char_pos < 4'd15) ? char_pos + 4'd1 : 4'd15;
    if (pos <= 4'd4) begin
      if (ch >= CHAR_A && ch <= CHAR_Z)
        code_sum = code_sum + (14'(letter_value(ch)) << (pos - 4'd1));
      else
        letter_bad = 1'b1;
    end else if (pos <= 4'd10) begin
      if (ch >= CHAR_0 && ch <= CHAR_9)
        code_sum = code_sum + (14'(ch - CHAR_0) << (pos - 4'd1));
      else
        digit_bad = 1'b1;
    end else if (pos == 4'd11) begin
      check_char = ch;
    end
    char_pos = pos;
    if (lst) begin
      digit = 4'(code_sum % 14'd11);
      if (digit == 4'd10) digit = 4'd0;
      if (pos < 4'd10)
        st = ST_SHORT;
      else if (letter_bad)
        st = ST_BADLET;
      else if (digit_bad)
        st = ST_BADDIG;
      else if (pos == 4'd10)
        st = corr_en ? ST_APPENDED : ST_MISSING;
      else if (pos == 4'd11 && check_char != CHAR_0 + 8'(digit))
        st = corr_en ? ST_CORRECTED : ST_MISMATCH;
      else
        st = ST_PASS;
      r.status      = st;
      r.accepted    = (st == ST_PASS || st == ST_APPENDED || st == ST_CORRECTED);
      r.check_digit = digit;
      r.code_length = pos;
      verdict_q.push_back(r);
      clear_code();
    end
  endfunction

  function automatic void log_fail(input string what, input result_t want,
                                   input result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected status=%0d acc=%0b digit=%0d len=%0d,",
               $time, what, want.status, want.accepted, want.check_digit,
               want.code_length);
      $display("    got status=%0d acc=%0b digit=%0d len=%0d",
               got.status, got.accepted, got.check_digit, got.code_length);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      verdict_q.delete();
      corr_en     = 1'b0;
      status_seen = '0;
      clear_code();
    end else begin
      // register port: track writes, check read data
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == CORRECT_EN_ADDR) begin
        if (cfg_pwrite) begin
          corr_en = cfg_pwdata[0];
        end else if (cfg_prdata !== {31'd0, corr_en}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: register read: expected %0h, got %0h",
                     $time, {31'd0, corr_en}, cfg_prdata);
        end
      end

      // result item against the oldest verdict
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[11:0]);
        status_seen[got.status] = 1'b1;
        if (verdict_q.size() == 0) begin
          log_fail("result with none expected", '0, got);
        end else begin
          want = verdict_q.pop_front();
          checked++;
          if (got.status !== want.status || got.accepted !== want.accepted ||
              got.check_digit !== want.check_digit ||
              got.code_length !== want.code_length || out_tdata[15:12] !== 4'd0)
            log_fail("result mismatch", want, got);
        end
      end

      // character item
      if (in_tvalid && in_tready)
        absorb_char(in_tdata, in_tlast);
    end
    pending <= verdict_q.size();
  end

endmodule

>>> tb/container_code_check_digit_tb.sv
// ---------------------------------------------------------------------------
// container_code_check_digit_tb
// Drives container codes into the check digit block, one character per
// item, with correction switched off and on between phases. Directed codes
// come first, then random codes that are mostly well formed with random
// corruption, short and over-long codes and pure noise. Both channels idle
// at random; one phase holds the result side off for a long stretch.
// ---------------------------------------------------------------------------
module container_code_check_digit_tb;

  localparam logic [2:0] CORRECT_EN_ADDR = 3'd0;
  localparam int         PHASE_CHARS     = 425;
  localparam int         HOLD_CYCLES     = 300;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;   // [7:0] char_code
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;            // [2:0] status, [3] accepted,
                                     // [7:4] check_digit, [11:8] code_length
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic        idle_on   = 1'b1;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int          fail_count;
  int          pending;
  int          checked;
  logic [7:0]  status_seen;
  int          chars_sent;
  int          codes_sent;
  logic [7:0]  code_buf[$];

  container_code_check_digit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ccd_code_checker #(.CORRECT_EN_ADDR(CORRECT_EN_ADDR)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .status_seen (status_seen)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("** container_code_check_digit: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 10);
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    return 8'("A") + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // One register access: setup cycle, then access cycle
  task automatic cfg_access(input logic wr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CORRECT_EN_ADDR;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the correction bit (junk in the upper bits), then read it back
  task automatic set_correction(input logic en);
    logic [31:0] data;
    data    = $urandom();
    data[0] = en;
    cfg_access(1'b1, data);
    cfg_access(1'b0, 32'd0);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic lst);
    while (idle_on && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_code_buf();
    for (int i = 0; i < code_buf.size(); i++)
      send_char(code_buf[i], i == code_buf.size() - 1);
    codes_sent++;
    code_buf.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      code_buf.push_back(s[i]);
  endtask

  // Mostly well-formed codes with random content, then short codes and noise
  task automatic build_random_code();
    int shape;
    int tail;
    int n;
    code_buf.delete();
    shape = $urandom_range(99);
    if (shape < 70) begin
      repeat (4) code_buf.push_back(rand_letter());
      repeat (6) code_buf.push_back(rand_digit());
      tail = $urandom_range(99);
      if (tail < 50) begin
        code_buf.push_back(rand_digit());
      end else if (tail >= 65 && tail < 80) begin
        code_buf.push_back(rand_byte());
      end else if (tail >= 80) begin
        code_buf.push_back(rand_digit());
        repeat ($urandom_range(1, 8)) code_buf.push_back(rand_byte());
      end
      // occasional corruption anywhere in the code
      if ($urandom_range(99) < 20)
        code_buf[$urandom_range(code_buf.size() - 1)] = rand_byte();
    end else if (shape < 85) begin
      n = $urandom_range(1, 9);
      for (int i = 1; i <= n; i++) begin
        if ($urandom_range(99) < 25)
          code_buf.push_back(rand_byte());
        else
          code_buf.push_back(i <= 4 ? rand_letter() : rand_digit());
      end
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) code_buf.push_back(rand_byte());
    end
  endtask

  task automatic run_random(input int n_chars);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      build_random_code();
      send_code_buf();
    end
  endtask

  // Let every outstanding verdict drain before touching the register
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // correction off: byte extremes as one-char codes, a valid code,
    // and the same code with a character past the check digit
    set_correction(1'b0);
    code_buf.push_back(8'h00);
    send_code_buf();
    code_buf.push_back(8'hFF);
    send_code_buf();
    push_text("CSQU3054383");
    send_code_buf();
    push_text("CSQU3054383");
    code_buf.push_back(8'hFF);
    send_code_buf();
    run_random(PHASE_CHARS - 25);
    settle();

    // correction on: result side held off while one-char codes pile up
    set_correction(1'b1);
    hold_req = 1'b1;
    repeat (12) begin
      code_buf.push_back(rand_byte());
      send_code_buf();
    end
    run_random(PHASE_CHARS);
    settle();

    // correction off, no idling on either side
    idle_on = 1'b0;
    set_correction(1'b0);
    run_random(PHASE_CHARS);
    settle();
    idle_on = 1'b1;

    // correction on again
    set_correction(1'b1);
    run_random(PHASE_CHARS);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d codes (%0d characters) over both correction settings, %0d checked",
             codes_sent, chars_sent, checked);
    $display("Result status codes seen, one bit per code: %08b", status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** container_code_check_digit: PASSED **");
    end else begin
      $display("** container_code_check_digit: FAILED **");
    end
    $finish;
  end

endmodule
